// File: design/gsm7u_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the GSM 7-bit septet unpacker.
// No dependencies; used by the interfaces and every module.
package gsm7u_pkg;

   localparam int OCTET_W   = 8;
   localparam int SEPTET_W  = 7;
   localparam int CHAR_W    = 8;
   localparam int COUNT_W   = 8;
   localparam int BUF_W     = 2 * SEPTET_W;
   localparam int HELD_W    = 4;

   // csr register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_AT_NULL = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUT_CAPACITY = 1'b1;

   localparam logic [COUNT_W-1:0] OUT_CAPACITY_RESET = 8'd160;

   localparam logic [CHAR_W-1:0] NULL_SEPTET_CHAR = 8'd183;
   localparam logic [CHAR_W-1:0] TERMINATOR_CHAR  = 8'd0;

   // work queue between front and back
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_ADDR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_W = $clog2(QUEUE_DEPTH + 1);

   // one queued octet: one or two characters to send
   typedef struct packed {
      logic [CHAR_W-1:0] ch0;
      logic [CHAR_W-1:0] ch1;
      logic              two;   // ch1 is valid
      logic              done;  // last character ends the message
   } entry_type;

endpackage

// File: design/gsm7u_intf.sv
`timescale 1ns / 1ps
// Channel interfaces of the septet unpacker: request, response, csr write.
// Depends on gsm7u_pkg.
interface gsm7u_req_if import gsm7u_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [OCTET_W-1:0] octet;
   logic               start_req;
   logic [COUNT_W-1:0] septet_limit;
   modport source(output valid, octet, start_req, septet_limit, input ready);
   modport sink(input valid, octet, start_req, septet_limit, output ready);
endinterface

interface gsm7u_rsp_if import gsm7u_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] character;
   logic              last_of_run;
   logic              message_done;
   modport source(output valid, character, last_of_run, message_done, input ready);
   modport sink(input valid, character, last_of_run, message_done, output ready);
endinterface

interface gsm7u_csr_if import gsm7u_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [COUNT_W-1:0]     data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// File: design/gsm7u_front.sv
`timescale 1ns / 1ps
// Front end: csr registers, bit buffer and message state; turns each octet
// into a queue entry of one or two characters. Depends on gsm7u_pkg, gsm7u_intf.
module gsm7u_front import gsm7u_pkg::*; #(
   parameter int MAX_SEPTETS = 160
) (
   input  logic        clock,
   input  logic        reset,
   gsm7u_req_if.sink   req_ch,
   gsm7u_csr_if.sink   csr_ch,
   input  logic        q_ready,
   output logic        push,
   output entry_type   push_entry
);

   localparam logic [COUNT_W-1:0] MaxLimit = COUNT_W'(MAX_SEPTETS);

   logic               stop_at_null_ff, stop_at_null_in;
   logic [COUNT_W-1:0] out_capacity_ff, out_capacity_in;
   logic [BUF_W-1:0]   buf_ff, buf_in;
   logic [HELD_W-1:0]  held_ff, held_in;
   logic [COUNT_W-1:0] emitted_ff, emitted_in;
   logic [COUNT_W-1:0] limit_ff, limit_in;
   logic               finished_ff, finished_in;

   logic               accept;
   logic [COUNT_W-1:0] sat_limit;
   logic [BUF_W-1:0]   eff_buf, buf_new;
   logic [HELD_W-1:0]  eff_held, held_sum;
   logic [COUNT_W-1:0] eff_emitted, eff_limit, e1, e2, emitted_next;
   logic               eff_finished;
   logic [SEPTET_W-1:0] c0, c1;
   logic               null0, null1, end0, end1, r1_valid, ended;

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = q_ready;
   assign accept       = req_ch.valid && q_ready;

   always_comb begin
      stop_at_null_in = stop_at_null_ff;
      out_capacity_in = out_capacity_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_STOP_AT_NULL: stop_at_null_in = csr_ch.data[0];
            CSR_OUT_CAPACITY: out_capacity_in = csr_ch.data;
            default: ;
         endcase
      end
   end

   // limit sampled at start: min(septet_limit, out_capacity, MAX_SEPTETS)
   always_comb begin
      sat_limit = req_ch.septet_limit;
      if (sat_limit > out_capacity_ff) sat_limit = out_capacity_ff;
      if (sat_limit > MaxLimit) sat_limit = MaxLimit;
   end

   always_comb begin
      if (req_ch.start_req) begin
         eff_buf      = '0;
         eff_held     = '0;
         eff_emitted  = '0;
         eff_limit    = sat_limit;
         eff_finished = (sat_limit == '0);
      end else begin
         eff_buf      = buf_ff;
         eff_held     = held_ff;
         eff_emitted  = emitted_ff;
         eff_limit    = limit_ff;
         eff_finished = finished_ff;
      end

      // held never exceeds 6, so the shifted octet fits the 14-bit buffer
      buf_new  = eff_buf | BUF_W'({{(BUF_W-OCTET_W){1'b0}}, req_ch.octet} << eff_held);
      held_sum = eff_held + HELD_W'(OCTET_W);
      c0       = buf_new[SEPTET_W-1:0];
      c1       = buf_new[BUF_W-1:SEPTET_W];

      null0    = (c0 == '0) && stop_at_null_ff;
      e1       = eff_emitted + COUNT_W'(1);
      end0     = null0 || (e1 >= eff_limit);
      r1_valid = (held_sum >= HELD_W'(BUF_W)) && !end0;
      null1    = (c1 == '0) && stop_at_null_ff;
      e2       = e1 + COUNT_W'(1);
      end1     = null1 || (e2 >= eff_limit);
      ended    = end0 || (r1_valid && end1);

      if (r1_valid) emitted_next = null1 ? e1 : e2;
      else          emitted_next = null0 ? eff_emitted : e1;

      push_entry.ch0  = null0 ? TERMINATOR_CHAR :
                        (c0 == '0) ? NULL_SEPTET_CHAR : {1'b0, c0};
      push_entry.ch1  = null1 ? TERMINATOR_CHAR :
                        (c1 == '0) ? NULL_SEPTET_CHAR : {1'b0, c1};
      push_entry.two  = r1_valid;
      push_entry.done = ended;
      push            = accept && !eff_finished;

      buf_in      = buf_ff;
      held_in     = held_ff;
      emitted_in  = emitted_ff;
      limit_in    = limit_ff;
      finished_in = finished_ff;
      if (accept) begin
         limit_in = eff_limit;
         if (eff_finished) begin
            buf_in      = '0;
            held_in     = '0;
            emitted_in  = eff_emitted;
            finished_in = 1'b1;
         end else begin
            emitted_in  = emitted_next;
            finished_in = ended;
            if (ended || r1_valid) begin
               buf_in  = '0;
               held_in = '0;
            end else begin
               buf_in  = buf_new >> SEPTET_W;
               held_in = held_sum - HELD_W'(SEPTET_W);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_at_null_ff <= 1'b0;
         out_capacity_ff <= OUT_CAPACITY_RESET;
         buf_ff          <= '0;
         held_ff         <= '0;
         emitted_ff      <= '0;
         limit_ff        <= '0;
         finished_ff     <= 1'b1;
      end else begin
         stop_at_null_ff <= stop_at_null_in;
         out_capacity_ff <= out_capacity_in;
         buf_ff          <= buf_in;
         held_ff         <= held_in;
         emitted_ff      <= emitted_in;
         limit_ff        <= limit_in;
         finished_ff     <= finished_in;
      end
   end

   a_held_short: assert property (@(posedge clock) disable iff (reset)
      held_ff < HELD_W'(SEPTET_W))
      else $error("bit buffer holds a full septet between octets");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> (held_ff == '0 && buf_ff == '0))
      else $error("leftover bits kept after message end");

   a_below_limit: assert property (@(posedge clock) disable iff (reset)
      !finished_ff |-> (emitted_ff < limit_ff))
      else $error("active message at or past its septet limit");

endmodule

// File: design/gsm7u_queue.sv
`timescale 1ns / 1ps
// Short FIFO of queue entries between front and back.
// Depends on gsm7u_pkg.
module gsm7u_queue import gsm7u_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      not_full,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head
);

   entry_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_ADDR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_ADDR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_W-1:0] count_ff, count_in;
   logic                     do_pop;

   assign not_full   = (count_ff != QUEUE_COUNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_ADDR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_ADDR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QUEUE_COUNT_W'(push) - QUEUE_COUNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> not_full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == QUEUE_COUNT_W'(QUEUE_DEPTH))
         == (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

// File: design/gsm7u_back.sv
`timescale 1ns / 1ps
// Back end: walks the head queue entry one character per word into the
// response output register. Depends on gsm7u_pkg, gsm7u_intf.
module gsm7u_back import gsm7u_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  entry_type   head,
   output logic        pop,
   gsm7u_rsp_if.source rsp_ch
);

   logic              valid_ff, valid_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic              last_ff, last_in;
   logic              done_ff, done_in;
   logic              phase_ff, phase_in;   // 1: sending second character
   logic              load;

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.character    = char_ff;
   assign rsp_ch.last_of_run  = last_ff;
   assign rsp_ch.message_done = done_ff;

   assign load = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      done_in  = done_ff;
      phase_in = phase_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = head_valid;
         if (head_valid) begin
            char_in  = phase_ff ? head.ch1 : head.ch0;
            last_in  = !head.two || phase_ff;
            done_in  = head.done && last_in;
            pop      = last_in;
            phase_in = !last_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
      done_ff <= done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && done_ff) |-> last_ff)
      else $error("message end flagged on a non-final word");

   a_phase_has_work: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (head_valid && head.two))
      else $error("second character pending without a two-character entry");

   a_second_is_last: assert property (@(posedge clock) disable iff (reset)
      (load && head_valid && phase_ff) |=> last_ff)
      else $error("second character not marked last of run");

endmodule

// File: design/gsm7_septet_unpacker.sv
`timescale 1ns / 1ps
// GSM 7-bit septet unpacker, top level. Depends on gsm7u_pkg, gsm7u_intf,
// gsm7u_front, gsm7u_queue, gsm7u_back.
// The first character word of an octet is valid on rsp once it has passed
// through the queue and the back-end output register.
// Throughput: up to one octet per cycle; one rsp word per cycle while rsp is
// ready, so an octet that yields two characters takes two rsp words (req
// stalls only when the queue is full).
// Reset (sync, active high): queue empty, no message active, stop_at_null 0,
// out_capacity 160.
module gsm7_septet_unpacker import gsm7u_pkg::*; #(
   parameter int MAX_SEPTETS = 160
) (
   input  logic        clock,
   input  logic        reset,
   gsm7u_req_if.sink   req_ch,
   gsm7u_rsp_if.source rsp_ch,
   gsm7u_csr_if.sink   csr_ch
);

   // front -> queue
   logic      push;
   logic      q_not_full;
   entry_type push_entry;

   // queue -> back
   logic      head_valid;
   logic      pop;
   entry_type head;

   // Front: csr regs, bit buffer, septet count and limit. Each accepted octet
   // is unpacked combinationally; an octet that yields characters leaves as one
   // queue entry. Octets arriving while no message is active are dropped.
   gsm7u_front #(
      .MAX_SEPTETS(MAX_SEPTETS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_ch     (csr_ch),
      .q_ready    (q_not_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // Queue decouples the octet rate from the character rate; req stalls only
   // when it fills.
   gsm7u_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .not_full   (q_not_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // Back: output register; it refills while the current word is taken.
   gsm7u_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule
